// ===== rtl/wto_pkg.sv =====
// shared constants, codes and types for the wavetable oscillator voice
package wto_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_FRAC_BITS   = 16;

  localparam int STEP_W     = 26;
  localparam int GAIN_W     = 16;
  localparam int TLEN_W     = 11;
  localparam int SMP_W      = 16;
  localparam int ADDR_W     = 10;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 26;
  localparam int IN_DATA_W  = 32;

  // widest multiplier operand: (b - a) * gain
  localparam int MUL_A_W = 34;

  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PHRST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TLEN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MUTED = 2'd3;

  localparam logic [STEP_W-1:0] RST_STEP = 26'd65536;
  localparam logic [GAIN_W-1:0] RST_GAIN = 16'd32768;
  localparam logic [TLEN_W-1:0] RST_TLEN = 11'd1024;

  typedef struct packed {
    logic busy;
    logic done;
  } wto_mod_stat_t;

endpackage

// ===== rtl/wto_mod.sv =====
// bit-serial remainder unit: one quotient bit per cycle, msb first
module wto_mod #(
  parameter int VW = 12,
  parameter int DW = 11
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VW-1:0]          value,
  input  logic [DW-1:0]          divisor,
  output logic [DW-1:0]          rem,
  output wto_pkg::wto_mod_stat_t stat
);
  import wto_pkg::*;

  localparam int CW = $clog2(VW + 1);

  logic [VW-1:0] val_r;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] div_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  always_comb begin
    trial = {rem_r, val_r[VW-1]};
    diff  = trial - {1'b0, div_r};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = diff[DW-1:0];
    end else begin
      rem_nxt = trial[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(VW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r <= value;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      val_r <= val_r << 1;
      rem_r <= rem_nxt;
    end
  end

  assign rem       = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

`ifndef ASSERT_OFF
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < div_r))
    else $error("remainder not below divisor");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start)
    else $error("remainder unit restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(busy_r) && !busy_r))
    else $error("done without a finished run");
`endif

endmodule

// ===== rtl/wavetable_oscillator_linear_interp.sv =====
// wavetable oscillator voice: phase accumulator, table store, interpolation and gain
//
// channel  ports      direction  contents
// in       in_t*      slave      tuser = mode, tdata = table_addr, table_value
// out      out_t*     master     tdata = sample
// cfg      cfg_*      slave      cfg_index selects register, cfg_data = value
//
// table writes, phase resets, muted ticks and other modes give a zero result in the cycle
// after they are accepted; a tick runs the bit-serial remainder unit on the phase index,
// reads two entries, multiplies on the shared multiplier, rounds and saturates, and runs
// the remainder unit again for the next phase before its sample is registered for output.
// the table has no reset; rst_n clears the phase and sets the registers to their reset values.
// in_tready is low while a tick is at work or the output register is held.
module wavetable_oscillator_linear_interp #(
  parameter int TABLE_DEPTH = wto_pkg::DEF_TABLE_DEPTH,
  parameter int FRAC_BITS   = wto_pkg::DEF_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [wto_pkg::IN_DATA_W-1:0]    in_tdata,   // [9:0] table_addr, [25:10] table_value
  input  logic [wto_pkg::MODE_W-1:0]       in_tuser,   // [1:0] mode
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [wto_pkg::SMP_W-1:0]        out_tdata,  // [15:0] sample
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wto_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wto_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import wto_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int LW     = $clog2(TABLE_DEPTH + 1);
  localparam int PH_W   = IDX_W + FRAC_BITS;
  localparam int SINT_W = STEP_W - FRAC_BITS;
  localparam int SW     = ((IDX_W > SINT_W) ? IDX_W : SINT_W) + 1;
  localparam int BW     = (FRAC_BITS + 1 > GAIN_W + 1) ? FRAC_BITS + 1 : GAIN_W + 1;
  localparam int PW     = MUL_A_W + BW;
  localparam int ACC_W  = PW + 1;
  localparam int SH     = 15 + FRAC_BITS;
  localparam int RW     = ACC_W - SH;

  localparam logic signed [ACC_W-1:0] RND_C  = ACC_W'(1) <<< (SH - 1);
  localparam logic signed [RW-1:0]    SAT_HI = RW'(32767);
  localparam logic signed [RW-1:0]    SAT_LO = RW'(-32768);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_MOD1 = 11'b00000000010,
    S_RDA  = 11'b00000000100,
    S_RDB  = 11'b00000001000,
    S_MAG  = 11'b00000010000,
    S_MDG  = 11'b00000100000,
    S_MQF  = 11'b00001000000,
    S_ACC  = 11'b00010000000,
    S_RND  = 11'b00100000000,
    S_MOD2 = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [STEP_W-1:0] step_r;
  logic [GAIN_W-1:0] gain_r;
  logic [TLEN_W-1:0] tlen_r;
  logic              muted_r;

  logic [PH_W-1:0]      phase_r;
  logic [IDX_W-1:0]     idx_r;
  logic [FRAC_BITS-1:0] frac_r;
  logic signed [SMP_W-1:0] a_r, b_r;
  logic [SMP_W-1:0]     rdata_r;
  logic signed [PW-1:0]    m_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [SMP_W-1:0] sample_r;
  logic                 out_valid_r;
  logic [SMP_W-1:0]     out_data_r;

  logic [SMP_W-1:0] mem [TABLE_DEPTH];

  logic [LW-1:0]    len_w;
  logic [IDX_W-1:0] nxt_idx;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_en;
  logic             wr_en;
  logic             in_acc;
  logic             tick_go;
  logic             slot_free;
  logic [FRAC_BITS:0] frac_sum;
  logic [SW-1:0]    sum_int;
  logic [SW-1:0]    mod_val;
  logic             mod_start;
  logic [LW-1:0]    mod_rem;
  wto_mod_stat_t    mod_stat;
  logic signed [SMP_W:0]     diff_s;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [BW-1:0]      mul_b;
  logic signed [RW-1:0]      rs;
  logic signed [SMP_W-1:0]   sat_w;

  assign cfg_ready  = 1'b1;
  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE) && slot_free;
  assign in_acc     = in_tvalid && in_tready;
  assign tick_go    = in_acc && (in_tuser == MODE_TICK) && !muted_r;
  assign wr_en      = in_acc && (in_tuser == MODE_WRITE) &&
                      (32'(in_tdata[ADDR_W-1:0]) < TABLE_DEPTH);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // effective table length, clamped to 2..TABLE_DEPTH
  always_comb begin
    if (tlen_r < TLEN_W'(2)) begin
      len_w = LW'(2);
    end else if (32'(tlen_r) > TABLE_DEPTH) begin
      len_w = LW'(TABLE_DEPTH);
    end else begin
      len_w = LW'(tlen_r);
    end
  end

  assign nxt_idx  = ((LW'(idx_r) + LW'(1)) == len_w) ? '0 : idx_r + IDX_W'(1);
  assign frac_sum = {1'b0, frac_r} + {1'b0, step_r[FRAC_BITS-1:0]};
  assign sum_int  = SW'(idx_r) + SW'(step_r[STEP_W-1:FRAC_BITS]) + SW'(frac_sum[FRAC_BITS]);
  assign mod_val  = (state_r == S_IDLE) ? SW'(phase_r[PH_W-1:FRAC_BITS]) : sum_int;
  assign mod_start = tick_go || (state_r == S_RND);
  assign rd_en    = (state_r == S_RDA) || (state_r == S_RDB);
  assign rd_addr  = (state_r == S_RDA) ? idx_r : nxt_idx;
  assign diff_s   = {b_r[SMP_W-1], b_r} - {a_r[SMP_W-1], a_r};

  wto_mod #(
    .VW(SW),
    .DW(LW)
  ) u_mod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mod_start),
    .value  (mod_val),
    .divisor(len_w),
    .rem    (mod_rem),
    .stat   (mod_stat)
  );

  // shared multiplier operand selection
  always_comb begin
    unique case (state_r)
      S_MAG: begin
        mul_a = MUL_A_W'(a_r);
        mul_b = BW'($signed({1'b0, gain_r}));
      end
      S_MDG: begin
        mul_a = MUL_A_W'(diff_s);
        mul_b = BW'($signed({1'b0, gain_r}));
      end
      S_MQF: begin
        mul_a = $signed(m_r[MUL_A_W-1:0]);
        mul_b = BW'($signed({1'b0, frac_r}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    rs = acc_r[ACC_W-1:SH];
    if (rs > SAT_HI) begin
      sat_w = SMP_W'(SAT_HI);
    end else if (rs < SAT_LO) begin
      sat_w = SMP_W'(SAT_LO);
    end else begin
      sat_w = rs[SMP_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (tick_go) state_nxt = S_MOD1;
      S_MOD1: if (mod_stat.done) state_nxt = S_RDA;
      S_RDA:  state_nxt = S_RDB;
      S_RDB:  state_nxt = S_MAG;
      S_MAG:  state_nxt = S_MDG;
      S_MDG:  state_nxt = S_MQF;
      S_MQF:  state_nxt = S_ACC;
      S_ACC:  state_nxt = S_RND;
      S_RND:  state_nxt = S_MOD2;
      S_MOD2: if (mod_stat.done) state_nxt = S_OUT;
      S_OUT:  if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= RST_STEP;
      gain_r      <= RST_GAIN;
      tlen_r      <= RST_TLEN;
      muted_r     <= 1'b0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_STEP:  step_r  <= cfg_data[STEP_W-1:0];
          REG_GAIN:  gain_r  <= cfg_data[GAIN_W-1:0];
          REG_TLEN:  tlen_r  <= cfg_data[TLEN_W-1:0];
          REG_MUTED: muted_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_acc && (in_tuser == MODE_PHRST)) begin
        phase_r <= '0;
      end else if ((state_r == S_MOD2) && mod_stat.done) begin
        phase_r <= {mod_rem[IDX_W-1:0], frac_sum[FRAC_BITS-1:0]};
      end
      if (in_acc && !tick_go) begin
        out_valid_r <= 1'b1;
      end else if ((state_r == S_OUT) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[IDX_W'(in_tdata[ADDR_W-1:0])] <= in_tdata[ADDR_W +: SMP_W];
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
    if (tick_go) begin
      frac_r <= phase_r[FRAC_BITS-1:0];
    end
    if ((state_r == S_MOD1) && mod_stat.done) begin
      idx_r <= mod_rem[IDX_W-1:0];
    end
    if (state_r == S_RDB) begin
      a_r <= $signed(rdata_r);
    end
    if (state_r == S_MAG) begin
      b_r <= $signed(rdata_r);
    end
    m_r <= PW'(mul_a) * PW'(mul_b);
    if (state_r == S_MDG) begin
      acc_r <= ACC_W'(m_r) <<< FRAC_BITS;
    end else if (state_r == S_ACC) begin
      acc_r <= acc_r + ACC_W'(m_r) + RND_C;
    end
    if (state_r == S_RND) begin
      sample_r <= sat_w;
    end
    if (in_acc && !tick_go) begin
      out_data_r <= '0;
    end else if ((state_r == S_OUT) && slot_free) begin
      out_data_r <= sample_r;
    end
  end

`ifndef ASSERT_OFF
  a_mod_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mod_stat.done |-> ((state_r == S_MOD1) || (state_r == S_MOD2)))
    else $error("remainder result outside a wait state");
  a_mod_busy_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mod_stat.busy |-> ((state_r == S_MOD1) || (state_r == S_MOD2)))
    else $error("remainder unit running outside a wait state");
  a_muted_holds_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == MODE_TICK) && muted_r) |=> $stable(phase_r))
    else $error("muted tick moved the phase");
  a_short_item_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !tick_go) |=> (out_valid_r && (out_data_r == '0) && (state_r == S_IDLE)))
    else $error("one-cycle item gave no zero result");
  a_phase_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_MOD2) && mod_stat.done) |=> (LW'(phase_r[PH_W-1:FRAC_BITS]) < len_w))
    else $error("updated phase beyond table span");
`endif

endmodule

// ===== verif/wavetable_oscillator_linear_interp_test.sv =====
// self-checking testbench for the wavetable oscillator voice
`timescale 1ns / 100ps

module wavetable_oscillator_linear_interp_test;
  import wto_pkg::*;

  localparam int DEPTH = DEF_TABLE_DEPTH;
  localparam int FRAC  = DEF_FRAC_BITS;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [MODE_W-1:0]     in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [SMP_W-1:0]      out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  wavetable_oscillator_linear_interp i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // voice state as the block should hold it
  logic [STEP_W-1:0]     step_reg;
  logic [GAIN_W-1:0]     gain_reg;
  logic [TLEN_W-1:0]     tlen_reg;
  logic                  muted_reg;
  longint unsigned       phase_acc;
  logic signed [15:0]    wave_mirror [DEPTH];
  bit                    wave_written [DEPTH];

  logic [SMP_W-1:0]      sample_due_q [$];
  logic [SMP_W-1:0]      sample_head;
  int                    fail_count;
  int                    hold_cycles;
  bit                    tx_idle_en;
  bit                    rx_idle_en;

  typedef struct packed {
    logic                  is_cfg;
    logic [1:0]            sel;     // mode for items, register for config rows
    logic [ADDR_W-1:0]     addr;
    logic [CFG_DATA_W-1:0] data;    // table word in the low 16 bits for items
    logic                  known;
    logic [SMP_W-1:0]      want;
  } dir_row_t;

  // starts from reset: step one entry, gain 1.0, full table
  dir_row_t dir_rows [0:30] = '{
    '{1'b0, MODE_WRITE, 10'd0,    26'h7FFF,    1'b1, 16'h0000},
    '{1'b0, MODE_WRITE, 10'd1,    26'h8000,    1'b1, 16'h0000},
    '{1'b0, MODE_WRITE, 10'd2,    26'h0000,    1'b1, 16'h0000},
    '{1'b0, MODE_WRITE, 10'd1023, 26'h4000,    1'b1, 16'h0000},
    '{1'b0, MODE_SPARE, 10'h3FF,  26'hFFFF,    1'b1, 16'h0000},
    '{1'b0, MODE_TICK,  10'd0,    26'h0,       1'b1, 16'h7FFF},
    '{1'b0, MODE_TICK,  10'd0,    26'h0,       1'b1, 16'h8000},
    '{1'b0, MODE_PHRST, 10'd0,    26'h0,       1'b1, 16'h0000},
    '{1'b1, REG_GAIN,   10'd0,    26'hFFFF,    1'b0, 16'h0000},
    '{1'b0, MODE_TICK,  10'd0,    26'h0,       1'b1, 16'h7FFF},   // saturates high
    '{1'b0, MODE_TICK,  10'd0,    26'h0,       1'b1, 16'h8000},   // saturates low
    '{1'b0, MODE_PHRST, 10'd0,    26'h0,       1'b1, 16'h0000},
    '{1'b1, REG_GAIN,   10'd0,    26'h0,       1'b0, 16'h0000},
    '{1'b0, MODE_TICK,  10'd0,    26'h0,       1'b1, 16'h0000},
    '{1'b0, MODE_PHRST, 10'd0,    26'h0,       1'b1, 16'h0000},
    '{1'b1, REG_TLEN,   10'd0,    26'h0,       1'b0, 16'h0000},   // acts as two entries
    '{1'b1, REG_GAIN,   10'd0,    26'h8000,    1'b0, 16'h0000},
    '{1'b1, REG_STEP,   10'd0,    26'h8000,    1'b0, 16'h0000},   // half an entry
    '{1'b0, MODE_TICK,  10'd0,    26'h0,       1'b1, 16'h7FFF},
    '{1'b0, MODE_TICK,  10'd0,    26'h0,       1'b0, 16'h0000},
    '{1'b0, MODE_TICK,  10'd0,    26'h0,       1'b1, 16'h8000},   // next entry wraps to 0
    '{1'b0, MODE_TICK,  10'd0,    26'h0,       1'b0, 16'h0000},
    '{1'b1, REG_MUTED,  10'd0,    26'h1,       1'b0, 16'h0000},
    '{1'b0, MODE_TICK,  10'd0,    26'h0,       1'b1, 16'h0000},
    '{1'b0, MODE_WRITE, 10'd5,    26'h1234,    1'b1, 16'h0000},
    '{1'b0, MODE_PHRST, 10'd0,    26'h0,       1'b1, 16'h0000},
    '{1'b1, REG_MUTED,  10'd0,    26'h0,       1'b0, 16'h0000},
    '{1'b1, REG_TLEN,   10'd0,    26'h7FF,     1'b0, 16'h0000},   // clamps to full depth
    '{1'b1, REG_STEP,   10'd0,    26'h3FFFFFF, 1'b0, 16'h0000},
    '{1'b0, MODE_TICK,  10'd0,    26'h0,       1'b1, 16'h7FFF},
    '{1'b0, MODE_TICK,  10'd0,    26'h0,       1'b0, 16'h0000}    // last entry to first
  };

  function automatic longint unsigned entries_in_use();
    if (tlen_reg < 2) return 2;
    if (tlen_reg > DEPTH) return DEPTH;
    return longint'(tlen_reg);
  endfunction

  // expected sample of one transaction; advances the mirrored voice state
  function automatic logic [SMP_W-1:0] voice_sample(logic [MODE_W-1:0] mode,
                                                   logic [ADDR_W-1:0] addr,
                                                   logic [15:0] value);
    longint unsigned len, span, pos, idx, nxt;
    longint a, b, f, s, p, r;
    voice_sample = '0;
    case (mode)
      MODE_WRITE: begin
        wave_mirror[addr]  = value;
        wave_written[addr] = 1'b1;
      end
      MODE_TICK: begin
        if (!muted_reg) begin
          len  = entries_in_use();
          span = len << FRAC;
          pos  = phase_acc % span;
          idx  = pos >> FRAC;
          nxt  = (idx + 1 == len) ? 0 : idx + 1;
          f    = longint'(pos & ((longint'(1) << FRAC) - 1));
          a    = longint'(wave_mirror[idx]);
          b    = longint'(wave_mirror[nxt]);
          s    = a * (longint'(1) << FRAC) + (b - a) * f;
          p    = s * longint'(gain_reg);
          r    = (p + (longint'(1) << (14 + FRAC))) >>> (15 + FRAC);
          if (r > 32767) r = 32767;
          if (r < -32768) r = -32768;
          voice_sample = r[SMP_W-1:0];
          phase_acc = (pos + longint'(step_reg)) % span;
        end
      end
      MODE_PHRST: phase_acc = 0;
      default: ;
    endcase
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (sample_due_q.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected sample %0d with nothing pending", $signed(out_tdata));
        fail_count++;
      end else begin
        sample_head = sample_due_q.pop_front();
        if (out_tdata !== sample_head) begin
          if (fail_count < 10)
            $display("sample mismatch: expected %0d got %0d",
                     $signed(sample_head), $signed(out_tdata));
          fail_count++;
        end
      end
    end
  end

  task automatic send_item(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] addr,
                           logic [15:0] value, logic known, logic [SMP_W-1:0] want);
    logic [SMP_W-1:0] pred;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {6'b0, value, addr};
    do @(posedge clk); while (!in_tready);
    pred = voice_sample(mode, addr, value);
    sample_due_q.push_back(known ? want : pred);
    if (tx_idle_en && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // the entries the next tick reads must have been written
  task automatic cover_tick_reads();
    longint unsigned len, pos, idx, nxt;
    len = entries_in_use();
    pos = phase_acc % (len << FRAC);
    idx = pos >> FRAC;
    nxt = (idx + 1 == len) ? 0 : idx + 1;
    if (!wave_written[idx]) send_item(MODE_WRITE, idx[ADDR_W-1:0], pick_word(), 1'b0, '0);
    if (!wave_written[nxt]) send_item(MODE_WRITE, nxt[ADDR_W-1:0], pick_word(), 1'b0, '0);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sample_due_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_STEP:  step_reg  = value[STEP_W-1:0];
      REG_GAIN:  gain_reg  = value[GAIN_W-1:0];
      REG_TLEN:  tlen_reg  = value[TLEN_W-1:0];
      REG_MUTED: muted_reg = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic random_item();
    int unsigned pick;
    logic [ADDR_W-1:0] addr;
    pick = $urandom_range(0, 99);
    addr = ADDR_W'($urandom);
    if (pick < 55) begin
      if (!muted_reg) cover_tick_reads();
      send_item(MODE_TICK, addr, 16'($urandom), 1'b0, '0);
    end else if (pick < 80) begin
      if ($urandom_range(0, 3) != 0)
        addr = ADDR_W'($urandom_range(0, 32'(entries_in_use() - 1)));
      send_item(MODE_WRITE, addr, pick_word(), 1'b0, '0);
    end else if (pick < 90) begin
      send_item(MODE_PHRST, addr, 16'($urandom), 1'b0, '0);
    end else begin
      send_item(MODE_SPARE, addr, 16'($urandom), 1'b0, '0);
    end
  endtask

  initial begin
    logic [TLEN_W-1:0]  new_tlen;
    logic [STEP_W-1:0]  new_step;
    logic [GAIN_W-1:0]  new_gain;
    logic               new_muted;
    longint unsigned    len;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    fail_count  = 0;
    hold_cycles = 0;
    tx_idle_en  = 1'b1;
    rx_idle_en  = 1'b1;
    step_reg    = RST_STEP;
    gain_reg    = RST_GAIN;
    tlen_reg    = RST_TLEN;
    muted_reg   = 1'b0;
    phase_acc   = 0;
    foreach (wave_written[i]) wave_written[i] = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        wait_idle();
        write_cfg(dir_rows[i].sel, dir_rows[i].data);
      end else begin
        if (dir_rows[i].sel == MODE_TICK && !muted_reg) cover_tick_reads();
        send_item(dir_rows[i].sel, dir_rows[i].addr, dir_rows[i].data[15:0],
                  dir_rows[i].known, dir_rows[i].want);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      // sender holds off until every pending sample is back
      wait_idle();
      case (ph)
        0:       new_tlen = 11'd2;
        1:       new_tlen = 11'd1024;
        default: new_tlen = ($urandom_range(0, 3) == 0) ? 11'($urandom)
                                                        : 11'($urandom_range(2, 40));
      endcase
      write_cfg(REG_TLEN, CFG_DATA_W'(new_tlen));
      len = entries_in_use();
      case ($urandom_range(0, 3))
        0:       new_step = STEP_W'($urandom);
        1:       new_step = STEP_W'($urandom_range(0, 32'((len << FRAC) - 1)));
        default: new_step = STEP_W'($urandom_range(0, 3 << FRAC));
      endcase
      if (ph == 0) new_step = '0;
      case ($urandom_range(0, 5))
        0:       new_gain = '0;
        1:       new_gain = '1;
        2:       new_gain = RST_GAIN;
        default: new_gain = GAIN_W'($urandom);
      endcase
      new_muted = (ph > 1) && ($urandom_range(0, 5) == 0);
      write_cfg(REG_STEP, CFG_DATA_W'(new_step));
      write_cfg(REG_GAIN, CFG_DATA_W'(new_gain));
      write_cfg(REG_MUTED, CFG_DATA_W'(new_muted));

      tx_idle_en = (ph != 5) && (ph != 7);
      rx_idle_en = (ph != 5) && (ph != 7);
      // long receiver hold-off while the sender keeps offering
      if (ph == 3) hold_cycles = 400;
      repeat (50) random_item();
    end

    wait_idle();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && sample_due_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
